@@ src/multi_task_heartbeat_watchdog_unit_macros.svh @@
// Assertion helpers shared by the watchdog monitor.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTHW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog monitor check failed");

// Next-cycle implication, checked outside reset.
`define MTHW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog monitor check failed");

`endif

@@ src/mthw_pkg.sv @@
package mthw_pkg;

  localparam int DATA_W   = 32;
  localparam int TIME_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int BCNT_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALIVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
  // The fourth code is undefined and is ignored.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WATCH_ENABLE = 2'd2;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100;

  // Write strobes and data for the handle and time-stamp stores.
  typedef struct packed {
    logic              we_handle;
    logic              we_stamp;
    logic [DATA_W-1:0] handle;
    logic [TIME_W-1:0] stamp;
  } tbl_wr_t;

  // Outcome of the shared compare unit for one table entry.
  typedef struct packed {
    logic match;
    logic late;
  } cmp_res_t;

endpackage

@@ src/multi_task_heartbeat_watchdog_unit.sv @@
// Heartbeat watchdog monitor for up to MAX_TASKS software tasks.
// A command word is taken on command and task_handle at a clock edge where
// start is high and busy is low. Register adds a handle to the next free
// slot, alive restamps a known handle, and tick advances the time counter
// and checks every active slot for a missed heartbeat.
// Each accepted word yields exactly one result word, held on the result
// ports for the single cycle in which done is high; the receiver cannot
// stall, so it must take the word in that cycle.
// One sequencer pass walks the occupied slots through a single compare
// unit behind a registered table read, then a finish state writes the
// result word and raises done. With watching disabled or an undefined
// command the scan is skipped. busy stays high meanwhile and a new word
// may be started in the cycle that done is shown.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must do so only while the block is idle, which the block itself
// leaves unchecked. Synchronous reset empties the table, clears the time
// counter and loads the register defaults; no clearing pass is needed.
module multi_task_heartbeat_watchdog_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mthw_pkg::CMD_W-1:0]     command,
  input  logic [mthw_pkg::DATA_W-1:0]    task_handle,
  output logic                           done,
  output logic [mthw_pkg::STAT_W-1:0]    status,
  output logic [mthw_pkg::SLOT_W-1:0]    assigned_slot,
  output logic                           refresh_watchdog,
  output logic                           blocked_found,
  output logic [mthw_pkg::SLOT_W-1:0]    blocked_index,
  output logic [mthw_pkg::BCNT_W-1:0]    blocked_count,
  output logic                           system_reset,
  input  logic                           cfg_write,
  input  logic [mthw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mthw_pkg::DATA_W-1:0]    cfg_data
);
  import mthw_pkg::*;

`include "multi_task_heartbeat_watchdog_unit_macros.svh"

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state;

  // Configuration registers.
  logic [TIME_W-1:0]   timeout_ticks;
  logic                reset_enable;
  logic                watch_enable;

  // Monitor state.
  logic [MAX_TASKS-1:0] entry_active;
  logic [CNT_W-1:0]     entry_count;
  logic [TIME_W-1:0]    current_time;

  // Latched command word.
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   handle_q;
  logic                act_q;

  // Scan pointer and the compare stage behind the table read.
  logic [CNT_W-1:0]    rd_idx;
  logic                pipe_valid;
  logic [IDX_W-1:0]    pipe_idx;

  // Scan accumulators: first hit, any hit and number of hits.
  logic                hit_any;
  logic [IDX_W-1:0]    hit_first;
  logic [CNT_W-1:0]    hit_count;

  logic [DATA_W-1:0]   rd_handle;
  logic [TIME_W-1:0]   rd_stamp;
  cmp_res_t            cmp_res;
  logic                hit;

  tbl_wr_t             tbl_wr;
  logic [IDX_W-1:0]    tbl_waddr;
  logic                commit_reg;

  logic [STAT_W-1:0]   res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_refresh;
  logic                res_found;
  logic [SLOT_W-1:0]   res_index;
  logic [BCNT_W-1:0]   res_count;
  logic                res_sysreset;

  logic                accept;
  logic                scan_issue;
  logic                scan_over;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign scan_issue = (state == S_SCAN) && (rd_idx < entry_count);
  assign scan_over  = (rd_idx >= entry_count) && !pipe_valid;

  mthw_table #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk       (clk),
    .raddr     (rd_idx[IDX_W-1:0]),
    .rd_handle (rd_handle),
    .rd_stamp  (rd_stamp),
    .waddr     (tbl_waddr),
    .wr        (tbl_wr)
  );

  // One compare unit serves all commands: handle equality for register and
  // alive, elapsed-time check for tick.
  mthw_cmp u_cmp (
    .active    (entry_active[pipe_idx]),
    .key       (handle_q),
    .rd_handle (rd_handle),
    .now       (current_time),
    .stamp     (rd_stamp),
    .timeout   (timeout_ticks),
    .res       (cmp_res)
  );

  assign hit = (cmd_q == CMD_TICK) ? cmp_res.late : cmp_res.match;

  // Result and table update, decided once the scan is over.
  always_comb begin
    res_status   = ST_OK;
    res_slot     = '0;
    res_refresh  = 1'b0;
    res_found    = 1'b0;
    res_index    = '0;
    res_count    = '0;
    res_sysreset = 1'b0;
    commit_reg   = 1'b0;
    tbl_waddr    = entry_count[IDX_W-1:0];
    tbl_wr       = '0;
    tbl_wr.handle = handle_q;
    tbl_wr.stamp  = current_time;
    if (act_q) begin
      unique case (cmd_q)
        CMD_REGISTER: begin
          priority if (handle_q == '0) begin
            res_status = ST_NULL;
          end else if (hit_any) begin
            res_status = ST_DUPLICATE;
          end else if (entry_count >= CNT_W'(MAX_TASKS)) begin
            res_status = ST_FULL;
          end else begin
            res_slot         = SLOT_W'(entry_count);
            commit_reg       = 1'b1;
            tbl_wr.we_handle = 1'b1;
            tbl_wr.we_stamp  = 1'b1;
          end
        end
        CMD_ALIVE: begin
          if ((handle_q == '0) || !hit_any) begin
            res_status = ST_UNKNOWN;
          end else begin
            res_refresh     = 1'b1;
            tbl_waddr       = hit_first;
            tbl_wr.we_stamp = 1'b1;
          end
        end
        CMD_TICK: begin
          res_refresh  = 1'b1;
          res_found    = hit_any;
          res_index    = SLOT_W'(hit_first);
          res_count    = BCNT_W'(hit_count);
          res_sysreset = hit_any && reset_enable;
        end
        default: begin
        end
      endcase
    end
    if (state != S_FIN) begin
      commit_reg       = 1'b0;
      tbl_wr.we_handle = 1'b0;
      tbl_wr.we_stamp  = 1'b0;
    end
  end

  // Control state, configuration and monitor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
      reset_enable  <= 1'b0;
      watch_enable  <= 1'b1;
      entry_active  <= '0;
      entry_count   <= '0;
      current_time  <= '0;
      rd_idx        <= '0;
      pipe_valid    <= 1'b0;
      hit_any       <= 1'b0;
      hit_count     <= '0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_TIMEOUT:      timeout_ticks <= cfg_data;
          REG_RESET_ENABLE: reset_enable  <= cfg_data[0];
          REG_WATCH_ENABLE: watch_enable  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_idx     <= '0;
            pipe_valid <= 1'b0;
            hit_any    <= 1'b0;
            hit_count  <= '0;
            if (watch_enable && (command != CMD_RESERVED)) begin
              // The tick scan already sees the advanced time.
              if (command == CMD_TICK) begin
                current_time <= current_time + TIME_W'(1);
              end
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          pipe_valid <= scan_issue;
          if (scan_issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (pipe_valid && hit) begin
            hit_any   <= 1'b1;
            hit_count <= hit_count + CNT_W'(1);
          end
          if (scan_over) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit_reg) begin
            entry_active[entry_count[IDX_W-1:0]] <= 1'b1;
            entry_count <= entry_count + CNT_W'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: command word, scan index and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= command;
      handle_q  <= task_handle;
      act_q     <= watch_enable && (command != CMD_RESERVED);
      hit_first <= '0;
    end else if ((state == S_SCAN) && pipe_valid && hit && !hit_any) begin
      hit_first <= pipe_idx;
    end
    if (scan_issue) begin
      pipe_idx <= rd_idx[IDX_W-1:0];
    end
    if (state == S_FIN) begin
      status           <= res_status;
      assigned_slot    <= res_slot;
      refresh_watchdog <= res_refresh;
      blocked_found    <= res_found;
      blocked_index    <= res_index;
      blocked_count    <= res_count;
      system_reset     <= res_sysreset;
    end
  end

  // A reset request is only ever raised alongside a blocked task.
  `MTHW_ASSERT_NOW(a_sysreset_needs_block, clk, rst, done && system_reset, blocked_found)
  // An accepted word always keeps the block busy in the next cycle.
  `MTHW_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  // A result is only produced at the end of a busy period.
  `MTHW_ASSERT_NOW(a_done_after_work, clk, rst, done, $past(busy) && !busy)
  // The table never holds more entries than it has slots.
  `MTHW_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(MAX_TASKS))

endmodule

@@ src/mthw_table.sv @@
module mthw_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  logic [IDX_W-1:0]            raddr,
  output logic [mthw_pkg::DATA_W-1:0] rd_handle,
  output logic [mthw_pkg::TIME_W-1:0] rd_stamp,
  input  logic [IDX_W-1:0]            waddr,
  input  mthw_pkg::tbl_wr_t           wr
);
  import mthw_pkg::*;

  logic [DATA_W-1:0] handle_mem [DEPTH];
  logic [TIME_W-1:0] stamp_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_handle) begin
      handle_mem[waddr] <= wr.handle;
    end
    if (wr.we_stamp) begin
      stamp_mem[waddr] <= wr.stamp;
    end
  end

  // Registered read: data for an address shows in the next cycle.
  always_ff @(posedge clk) begin
    rd_handle <= handle_mem[raddr];
    rd_stamp  <= stamp_mem[raddr];
  end

endmodule

@@ src/mthw_cmp.sv @@
module mthw_cmp (
  input  logic                        active,
  input  logic [mthw_pkg::DATA_W-1:0] key,
  input  logic [mthw_pkg::DATA_W-1:0] rd_handle,
  input  logic [mthw_pkg::TIME_W-1:0] now,
  input  logic [mthw_pkg::TIME_W-1:0] stamp,
  input  logic [mthw_pkg::TIME_W-1:0] timeout,
  output mthw_pkg::cmp_res_t          res
);
  import mthw_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // Elapsed time wraps modulo the counter width.
  assign elapsed   = now - stamp;
  assign res.match = active && (rd_handle == key);
  assign res.late  = active && (elapsed > timeout);

endmodule
